### rtl/osc_pkg.sv
// Shared constants, codes and types for the OSC message parser.
// No dependencies; compile first.
`default_nettype none

package osc_pkg;

    // Width of the byte position counter
    localparam int POSITION_BITS = 16;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    // Alignment of OSC fields is 4 bytes
    localparam int ALIGN_BITS = 2;

    // Parse phases
    localparam logic [2:0] PH_PATH      = 3'd0;
    localparam logic [2:0] PH_PATH_PAD  = 3'd1;
    localparam logic [2:0] PH_TAG_START = 3'd2;
    localparam logic [2:0] PH_TAGS      = 3'd3;
    localparam logic [2:0] PH_TAG_PAD   = 3'd4;
    localparam logic [2:0] PH_ARG       = 3'd5;
    localparam logic [2:0] PH_DROP      = 3'd6;

    // Result kinds
    localparam logic [1:0] KIND_PATH   = 2'd0;
    localparam logic [1:0] KIND_STRING = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // End statuses
    localparam logic [2:0] ST_DROPPED  = 3'd0;
    localparam logic [2:0] ST_NO_ARGS  = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FLOAT    = 3'd3;
    localparam logic [2:0] ST_INT      = 3'd4;
    localparam logic [2:0] ST_STRING   = 3'd5;
    localparam logic [2:0] ST_NO_VALUE = 3'd6;

    // Characters of interest
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_F     = 8'h66;
    localparam logic [7:0] CHAR_I     = 8'h69;
    localparam logic [7:0] CHAR_S     = 8'h73;

    // Argument word length in bytes
    localparam logic [2:0] ARG_BYTES = 3'd4;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  text_byte;
        logic [2:0]  end_status;
        logic [31:0] argument_word;
    } osc_result_t;

endpackage

`default_nettype wire

### rtl/osc_in_if.sv
// Valid/ready channel carrying datagram bytes into the parser.
// Depends on nothing but the handshake convention.
`default_nettype none

interface osc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_datagram;

    modport source (output valid, output data_byte, output end_of_datagram, input ready);
    modport sink   (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

`default_nettype wire

### rtl/osc_out_if.sv
// Valid/ready channel carrying parser results.
// Depends on nothing but the handshake convention.
`default_nettype none

interface osc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [7:0]  text_byte;
    logic [2:0]  end_status;
    logic [31:0] argument_word;

    modport source (output valid, output item_kind, output text_byte, output end_status,
                    output argument_word, input ready);
    modport sink   (input valid, input item_kind, input text_byte, input end_status,
                    input argument_word, output ready);
endinterface

`default_nettype wire

### rtl/osc_message_parser.sv
// OSC message parser top level: byte-wise phase tracker and result queue.
// Depends on osc_pkg, osc_in_if and osc_out_if.
`default_nettype none

// Channel    Dir  Word                                      Per datagram byte
// ---------  ---  ----------------------------------------  -----------------
// datagram   in   data_byte, end_of_datagram                one word
// result     out  item_kind, text_byte, end_status,         0, 1 or 2 words
//                 argument_word
//
// One byte is taken per cycle; its phase update is done in the same cycle and
// its results go into a four-word result queue. datagram.ready is high while
// the queue has room for two words, so with result.ready held high the block
// runs at one byte per cycle; only the final byte can add a second word.
// Reset (rst_n low, asynchronous) puts the parser in the path phase and
// empties the queue. A stall on result holds the queue; once three slots are
// taken the input is held off.

module osc_message_parser
    import osc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    osc_in_if.sink      datagram,
    osc_out_if.source   result
);

    // Parser state
    logic [2:0]               phase_reg,  phase_next;
    logic [POSITION_BITS-1:0] pos_reg,    pos_next;
    logic [7:0]               tag_reg,    tag_next;
    logic [1:0]               tcnt_reg,   tcnt_next;
    logic [31:0]              shift_reg,  shift_next;
    logic [2:0]               abytes_reg, abytes_next;
    logic [1:0]               sstat_reg,  sstat_next;
    logic                     ovf_reg,    ovf_next;

    // Result queue
    osc_result_t fifo_reg [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg,  count_next;

    logic        in_fire;
    logic        out_fire;
    logic        emit_text;
    logic [1:0]  text_kind;
    logic [2:0]  status;
    logic        boundary;
    logic        short_dgram;
    logic [1:0]  push_n;
    osc_result_t res0;
    osc_result_t res1;

    assign in_fire  = datagram.valid && datagram.ready;
    assign out_fire = result.valid && result.ready;

    // Next byte lands on a 4-aligned offset when this index ends in all ones
    assign boundary    = &pos_reg[ALIGN_BITS-1:0];
    // Datagram size (index + 1) below four
    assign short_dgram = (pos_reg < POSITION_BITS'(3));

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        tag_next    = tag_reg;
        tcnt_next   = tcnt_reg;
        shift_next  = shift_reg;
        abytes_next = abytes_reg;
        sstat_next  = sstat_reg;
        ovf_next    = ovf_reg;
        emit_text   = 1'b0;
        text_kind   = KIND_PATH;
        status      = ST_DROPPED;

        // Position saturates; a byte seen at all ones trips the drop
        if (pos_reg == POS_MAX)
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
        end
        if (ovf_next)
        begin
            phase_next = PH_DROP;
        end

        case (phase_next)
            PH_PATH:
            begin
                if (datagram.data_byte != CHAR_NUL)
                begin
                    emit_text = 1'b1;
                    text_kind = KIND_PATH;
                end
                else
                begin
                    phase_next = boundary ? PH_TAG_START : PH_PATH_PAD;
                end
            end
            PH_PATH_PAD:
            begin
                if (boundary)
                begin
                    phase_next = PH_TAG_START;
                end
            end
            PH_TAG_START:
            begin
                phase_next = (datagram.data_byte == CHAR_COMMA) ? PH_TAGS : PH_DROP;
            end
            PH_TAGS:
            begin
                if (datagram.data_byte != CHAR_NUL)
                begin
                    if (tcnt_reg == 2'd0)
                    begin
                        tag_next = datagram.data_byte;
                    end
                    if (tcnt_reg != 2'd3)
                    begin
                        tcnt_next = tcnt_reg + 2'd1;
                    end
                end
                else
                begin
                    phase_next = boundary ? PH_ARG : PH_TAG_PAD;
                end
            end
            PH_TAG_PAD:
            begin
                if (boundary)
                begin
                    phase_next = PH_ARG;
                end
            end
            PH_ARG:
            begin
                if (tcnt_reg != 2'd0 && (tag_reg == CHAR_F || tag_reg == CHAR_I))
                begin
                    if (abytes_reg < ARG_BYTES)
                    begin
                        shift_next  = {shift_reg[23:0], datagram.data_byte};
                        abytes_next = abytes_reg + 3'd1;
                    end
                end
                else if (tcnt_reg != 2'd0 && tag_reg == CHAR_S)
                begin
                    if (!sstat_reg[1])
                    begin
                        if (datagram.data_byte != CHAR_NUL)
                        begin
                            emit_text     = 1'b1;
                            text_kind     = KIND_STRING;
                            sstat_next[0] = 1'b1;
                        end
                        else
                        begin
                            sstat_next[1] = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Status as it would stand if this byte closed the datagram
        if (!(ovf_next || short_dgram))
        begin
            case (phase_next)
                PH_PATH_PAD, PH_TAG_START:
                begin
                    status = ST_NO_ARGS;
                end
                PH_ARG:
                begin
                    if (tcnt_next == 2'd0)
                    begin
                        status = ST_EMPTY;
                    end
                    else if (tag_next == CHAR_F)
                    begin
                        status = (abytes_next >= ARG_BYTES) ? ST_FLOAT : ST_NO_VALUE;
                    end
                    else if (tag_next == CHAR_I)
                    begin
                        status = (abytes_next >= ARG_BYTES) ? ST_INT : ST_NO_VALUE;
                    end
                    else if (tag_next == CHAR_S)
                    begin
                        status = (sstat_next == 2'b11) ? ST_STRING : ST_NO_VALUE;
                    end
                    else
                    begin
                        status = ST_NO_VALUE;
                    end
                end
                default:
                begin
                    status = ST_DROPPED;
                end
            endcase
        end

        // The result words
        res1.item_kind     = KIND_STATUS;
        res1.text_byte     = 8'h00;
        res1.end_status    = status;
        res1.argument_word = (status == ST_FLOAT || status == ST_INT) ? shift_next : 32'h0;

        if (emit_text)
        begin
            res0.item_kind     = text_kind;
            res0.text_byte     = datagram.data_byte;
            res0.end_status    = ST_DROPPED;
            res0.argument_word = 32'h0;
        end
        else
        begin
            res0 = res1;
        end

        // Final byte: everything back to its start value
        if (datagram.end_of_datagram)
        begin
            phase_next  = PH_PATH;
            pos_next    = '0;
            tag_next    = 8'h00;
            tcnt_next   = 2'd0;
            shift_next  = 32'h0;
            abytes_next = 3'd0;
            sstat_next  = 2'b00;
            ovf_next    = 1'b0;
        end
    end

    assign push_n = in_fire ? (2'(emit_text) + 2'(datagram.end_of_datagram)) : 2'd0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_n;
        rd_ptr_next = rd_ptr_reg + 2'(out_fire);
        count_next  = count_reg + 3'(push_n) - 3'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PATH;
            pos_reg    <= '0;
            tag_reg    <= 8'h00;
            tcnt_reg   <= 2'd0;
            shift_reg  <= 32'h0;
            abytes_reg <= 3'd0;
            sstat_reg  <= 2'b00;
            ovf_reg    <= 1'b0;
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                tag_reg    <= tag_next;
                tcnt_reg   <= tcnt_next;
                shift_reg  <= shift_next;
                abytes_reg <= abytes_next;
                sstat_reg  <= sstat_next;
                ovf_reg    <= ovf_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

    // Room for two words means any byte can be taken
    assign datagram.ready = (count_reg <= 3'd2);

    assign result.valid         = (count_reg != 3'd0);
    assign result.item_kind     = fifo_reg[rd_ptr_reg].item_kind;
    assign result.text_byte     = fifo_reg[rd_ptr_reg].text_byte;
    assign result.end_status    = fifo_reg[rd_ptr_reg].end_status;
    assign result.argument_word = fifo_reg[rd_ptr_reg].argument_word;

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking bench for osc_message_parser: datagram bytes in, path/string/status words out.
// Needs osc_pkg, osc_in_if, osc_out_if and the parser RTL; reads nothing else.
module testbench;
    import osc_pkg::*;

    localparam int MAX_GAP        = 12;
    localparam int ITEM_TARGET    = 1950;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int MIN_MESSAGE    = 4;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    osc_in_if  datagram_ch ();
    osc_out_if result_ch ();

    osc_message_parser u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .datagram (datagram_ch),
        .result   (result_ch)
    );

    always #5 clk = ~clk;

    // Words the parser still owes us, oldest first
    osc_result_t pending_results [$];

    // Bytes of the datagram being built
    logic [7:0] frame [$];

    // Upper bound of the random wait drawn per word on each side
    int src_gap_max  = MAX_GAP;
    int sink_gap_max = MAX_GAP;

    int bytes_sent     = 0;
    int frames_sent    = 0;
    int words_checked  = 0;
    int mismatch_count = 0;
    int status_tally [8];

    // Predicted parser state
    logic [2:0]  p_phase;
    int          p_pos;
    logic [7:0]  p_first_tag;
    int          p_tags;
    logic [31:0] p_arg;
    int          p_arg_bytes;
    logic        p_str_seen;
    logic        p_str_closed;
    logic        p_overflow;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic clear_tracker();
        p_phase      = PH_PATH;
        p_pos        = 0;
        p_first_tag  = CHAR_NUL;
        p_tags       = 0;
        p_arg        = '0;
        p_arg_bytes  = 0;
        p_str_seen   = 1'b0;
        p_str_closed = 1'b0;
        p_overflow   = 1'b0;
    endtask

    task automatic queue_result(input logic [1:0] kind, input logic [7:0] text,
                                input logic [2:0] status, input logic [31:0] word);
        osc_result_t r;
        r.item_kind     = kind;
        r.text_byte     = text;
        r.end_status    = status;
        r.argument_word = word;
        pending_results.push_back(r);
    endtask

    // Advance the tracked parser by one accepted byte and queue what it emits
    task automatic parse_datagram_byte(input logic [7:0] b, input logic last);
        int          idx;
        logic [31:0] next_pos;
        logic        boundary;
        logic [2:0]  status;
        idx = p_pos;
        // counter saturates at all ones; from then on the datagram is dead
        if (idx >= int'(POS_MAX))
            p_overflow = 1'b1;
        else
            p_pos = idx + 1;
        if (p_overflow)
            p_phase = PH_DROP;
        next_pos = idx + 1;
        boundary = (next_pos[ALIGN_BITS-1:0] == '0);

        case (p_phase)
            PH_PATH:
            begin
                if (b != CHAR_NUL)
                    queue_result(KIND_PATH, b, '0, '0);
                else
                    p_phase = boundary ? PH_TAG_START : PH_PATH_PAD;
            end
            PH_PATH_PAD:
            begin
                if (boundary)
                    p_phase = PH_TAG_START;
            end
            PH_TAG_START:
            begin
                p_phase = (b == CHAR_COMMA) ? PH_TAGS : PH_DROP;
            end
            PH_TAGS:
            begin
                if (b != CHAR_NUL)
                begin
                    if (p_tags == 0)
                        p_first_tag = b;
                    if (p_tags < 3)
                        p_tags++;
                end
                else
                    p_phase = boundary ? PH_ARG : PH_TAG_PAD;
            end
            PH_TAG_PAD:
            begin
                if (boundary)
                    p_phase = PH_ARG;
            end
            PH_ARG:
            begin
                if (p_tags != 0 && (p_first_tag == CHAR_F || p_first_tag == CHAR_I))
                begin
                    if (p_arg_bytes < ARG_BYTES)
                    begin
                        p_arg = {p_arg[23:0], b};
                        p_arg_bytes++;
                    end
                end
                else if (p_tags != 0 && p_first_tag == CHAR_S && !p_str_closed)
                begin
                    if (b != CHAR_NUL)
                    begin
                        queue_result(KIND_STRING, b, '0, '0);
                        p_str_seen = 1'b1;
                    end
                    else
                        p_str_closed = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (last)
        begin
            if (p_overflow || idx + 1 < MIN_MESSAGE)
                status = ST_DROPPED;
            else
            begin
                case (p_phase)
                    PH_PATH_PAD, PH_TAG_START:
                        status = ST_NO_ARGS;
                    PH_ARG:
                    begin
                        if (p_tags == 0)
                            status = ST_EMPTY;
                        else if (p_first_tag == CHAR_F)
                            status = (p_arg_bytes >= ARG_BYTES) ? ST_FLOAT : ST_NO_VALUE;
                        else if (p_first_tag == CHAR_I)
                            status = (p_arg_bytes >= ARG_BYTES) ? ST_INT : ST_NO_VALUE;
                        else if (p_first_tag == CHAR_S)
                            status = (p_str_seen && p_str_closed) ? ST_STRING : ST_NO_VALUE;
                        else
                            status = ST_NO_VALUE;
                    end
                    default:
                        status = ST_DROPPED;
                endcase
            end
            queue_result(KIND_STATUS, '0, status,
                         (status == ST_FLOAT || status == ST_INT) ? p_arg : 32'd0);
            clear_tracker();
        end
    endtask

    // ------------------------------------------------------------------
    // Sending side
    // ------------------------------------------------------------------

    // One byte over the datagram channel; valid is only dropped for a real gap,
    // never lowered and raised in the same step.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0)
        begin
            datagram_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        datagram_ch.valid           <= 1'b1;
        datagram_ch.data_byte       <= b;
        datagram_ch.end_of_datagram <= last;
        @(posedge clk);
        while (!datagram_ch.ready)
            @(posedge clk);
        parse_datagram_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
        frames_sent++;
    endtask

    // Hold the sender off until every owed word is back, then let the bench settle
    task automatic drain_results();
        datagram_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] nonzero_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    // Pad bytes are never looked at, so fill them with junk
    task automatic pad_frame();
        while (frame.size() % (1 << ALIGN_BITS) != 0)
            frame.push_back(8'($urandom));
    endtask

    // Mostly well-formed messages with random content; the rest noise,
    // missing terminators, a bad comma or a truncated tail.
    task automatic build_message();
        int         shape;
        int         ntags;
        int         cut;
        logic [7:0] lead_tag;
        logic [7:0] stray;
        frame.delete();
        shape = $urandom_range(0, 11);
        if (shape == 0)
        begin
            repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom));
            return;
        end
        repeat ($urandom_range(0, 9)) frame.push_back(nonzero_byte());
        if (shape == 1)
        begin
            // path never terminated
            repeat ($urandom_range(1, 6)) frame.push_back(nonzero_byte());
            return;
        end
        frame.push_back(CHAR_NUL);
        pad_frame();
        if (shape == 2)
        begin
            do
                stray = 8'($urandom);
            while (stray == CHAR_COMMA);
            frame.push_back(stray);
        end
        else
            frame.push_back(CHAR_COMMA);

        ntags    = $urandom_range(0, 4);
        lead_tag = CHAR_NUL;
        for (int k = 0; k < ntags; k++)
        begin
            if (k == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       lead_tag = CHAR_F;
                    1:       lead_tag = CHAR_I;
                    2:       lead_tag = CHAR_S;
                    default: lead_tag = nonzero_byte();
                endcase
                frame.push_back(lead_tag);
            end
            else
                frame.push_back(nonzero_byte());
        end
        // tag list left open
        if (shape == 3)
            return;
        frame.push_back(CHAR_NUL);
        pad_frame();

        if (lead_tag == CHAR_F || lead_tag == CHAR_I)
        begin
            repeat (ARG_BYTES) frame.push_back(8'($urandom));
        end
        else if (lead_tag == CHAR_S)
        begin
            repeat ($urandom_range(0, 8)) frame.push_back(nonzero_byte());
            frame.push_back(CHAR_NUL);
            pad_frame();
        end
        // further arguments, never parsed
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom));
        end
        if (shape == 4)
        begin
            cut = $urandom_range(1, frame.size());
            while (frame.size() > cut)
                void'(frame.pop_back());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_cases();
        src_gap_max  = MAX_GAP;
        sink_gap_max = MAX_GAP;
        // lone byte: too short, yet it still goes out as a path byte
        frame = {8'hFF};
        send_frame();
        // path only, datagram stops right at the tag offset
        frame = {8'h2F, CHAR_NUL, CHAR_NUL, CHAR_NUL};
        send_frame();
        // empty path, float of all ones, junk in the tag pad
        frame = {CHAR_NUL, 8'hFF, 8'hFF, 8'hFF, CHAR_COMMA, CHAR_F, CHAR_NUL, 8'hA5,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame();
        // string argument with a top-bit-only byte (80) and the largest 7-bit byte (7F)
        frame = {CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_COMMA, CHAR_S, CHAR_NUL, CHAR_NUL,
                 8'h80, 8'h7F, CHAR_NUL, CHAR_NUL};
        send_frame();
        drain_results();
    endtask

    task automatic test_random_messages();
        int start;
        int msgs;
        start = bytes_sent;
        msgs  = 0;
        while (bytes_sent - start < ITEM_TARGET)
        begin
            // roughly one message in four runs flat out on a given side
            src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            build_message();
            send_frame();
            msgs++;
            // every so often let the result queue run dry before carrying on
            if (msgs % 16 == 0)
                drain_results();
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Result side: pacing, checking, watchdog
    // ------------------------------------------------------------------

    initial
    begin : sink_pacing
        int hold;
        hold = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (result_ch.ready && result_ch.valid)
            begin
                // word taken: maybe stall before the next one
                hold = $urandom_range(0, sink_gap_max);
                if (hold > 0)
                begin
                    result_ch.ready <= 1'b0;
                    hold--;
                end
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input osc_result_t want,
                                   input osc_result_t seen);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] %s (kind/byte/status/arg): exp %0d/%02h/%0d/%08h %s",
                     $time, what, want.item_kind, want.text_byte, want.end_status,
                     want.argument_word,
                     $sformatf("got %0d/%02h/%0d/%08h", seen.item_kind, seen.text_byte,
                               seen.end_status, seen.argument_word));
    endtask

    always @(posedge clk)
    begin : result_check
        osc_result_t seen;
        osc_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            seen.item_kind     = result_ch.item_kind;
            seen.text_byte     = result_ch.text_byte;
            seen.end_status    = result_ch.end_status;
            seen.argument_word = result_ch.argument_word;
            words_checked++;
            if (seen.item_kind == KIND_STATUS)
                status_tally[seen.end_status]++;
            if (pending_results.size() == 0)
                report_mismatch("word with nothing owed", '0, seen);
            else
            begin
                want = pending_results.pop_front();
                if (seen.item_kind !== want.item_kind || seen.text_byte !== want.text_byte ||
                    seen.end_status !== want.end_status ||
                    seen.argument_word !== want.argument_word)
                    report_mismatch("wrong word", want, seen);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((datagram_ch.valid && datagram_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: %0d cycles with no word moving, %0d still owed",
                 WATCHDOG_LIMIT, pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin : run
        datagram_ch.valid           <= 1'b0;
        datagram_ch.data_byte       <= '0;
        datagram_ch.end_of_datagram <= 1'b0;
        clear_tracker();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_messages();

        $display("covered %0d bytes in %0d datagrams, %0d result words checked, %0d mismatches",
                 bytes_sent, frames_sent, words_checked, mismatch_count);
        $display("statuses: dropped %0d, no-args %0d, empty %0d, float %0d, int %0d, %s",
                 status_tally[ST_DROPPED], status_tally[ST_NO_ARGS], status_tally[ST_EMPTY],
                 status_tally[ST_FLOAT], status_tally[ST_INT],
                 $sformatf("string %0d, no-value %0d", status_tally[ST_STRING],
                           status_tally[ST_NO_VALUE]));
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
